// ----- sv/windowed_rate_statistics_unit_defines.svh -----
// Assertion macros for the windowed rate statistics unit.
// Used by the port checker; no other dependencies.
`ifndef WINDOWED_RATE_STATISTICS_UNIT_DEFINES_SVH
`define WINDOWED_RATE_STATISTICS_UNIT_DEFINES_SVH
// implication checked every clock edge outside reset
`define WRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define WRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- sv/wrs_pkg.sv -----
// Shared types and constants for the windowed rate statistics unit.
// No dependencies.
`default_nettype none
package wrs_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3; // no effect, snapshot only
    localparam logic CFG_MAX_DUR   = 1'b0;
    localparam logic CFG_RST_DELAY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;      // apply the item to the statistics registers
        logic div_start; // begin both channel divisions
        logic div_step;  // one quotient bit per channel
        logic div_done;  // write quotients to the rate registers
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;  // this item needs a rate recompute by division
    } t_stat;
endpackage
`default_nettype wire

// ----- sv/wrs_ctrl.sv -----
// Controller of the windowed rate statistics unit: handshake and divider sequencing.
// Depends on wrs_pkg.
`default_nettype none
module wrs_ctrl #(
    parameter int DIV_STEPS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_ready,
    input  wrs_pkg::t_stat      i_stat,
    output wrs_pkg::t_cmd       o_cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHK  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;
    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt   = CW'(DIV_STEPS);
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    o_cmd.div_done = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule
`default_nettype wire

// ----- sv/wrs_dpath.sv -----
// Datapath of the windowed rate statistics unit: statistics registers and
// two restoring dividers. Depends on wrs_pkg.
`default_nettype none
module wrs_dpath #(
    parameter int FRAC_BITS = wrs_pkg::FRAC_BITS_DEF,
    parameter int DIV_STEPS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wrs_pkg::t_cmd       i_cmd,
    output wrs_pkg::t_stat      o_stat,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_index,
    input  wire  [31:0]         i_cfg_data,
    input  wire  [1:0]          i_req_type,
    input  wire  signed [31:0]  i_mitigated_value,
    input  wire  signed [31:0]  i_unmitigated_value,
    input  wire                 i_is_critical,
    input  wire  [31:0]         i_delta_time,
    output logic [31:0]         o_sample_count,
    output logic [31:0]         o_crit_count,
    output logic                o_in_progress,
    output logic [31:0]         o_window_time,
    output logic signed [31:0]  o_mit_min,
    output logic signed [31:0]  o_mit_max,
    output logic signed [47:0]  o_mit_total,
    output logic signed [47:0]  o_mit_rate,
    output logic signed [31:0]  o_unm_min,
    output logic signed [31:0]  o_unm_max,
    output logic signed [47:0]  o_unm_total,
    output logic signed [47:0]  o_unm_rate
);
    localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};
    localparam logic [32:0] ONE = 33'(1) << FRAC_BITS;
    localparam int QW = DIV_STEPS; // quotient bits, magnitude is 48 bits << FRAC_BITS

    logic [31:0] r_max_dur, r_rst_delay;
    logic [31:0] r_cnt, r_crit, r_wt, r_idle;
    logic        r_run;
    logic signed [31:0] r_min [2];
    logic signed [31:0] r_max [2];
    logic signed [47:0] r_tsum [2];
    logic signed [47:0] r_tot [2];
    logic signed [47:0] r_rate [2];
    logic        r_need;
    // divider: remainder, dividend shift, quotient, sign
    logic [32:0] r_rem [2];
    logic [QW-1:0] r_dvd [2];
    logic [QW-1:0] r_quo [2];
    logic        r_neg [2];

    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        if (x > 49'(S48_MAX)) return S48_MAX;
        if (x < 49'(S48_MIN)) return S48_MIN;
        return x[47:0];
    endfunction

    function automatic logic [31:0] sadd32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    logic        full, sample_ok;
    logic [31:0] idle_nx;
    logic signed [31:0] v [2];
    assign full = (r_max_dur != 32'd0) && (r_wt >= r_max_dur);
    assign sample_ok = (i_req_type == wrs_pkg::REQ_SAMPLE) && !full;
    assign idle_nx = sadd32(r_idle, i_delta_time);
    assign v[0] = i_mitigated_value;
    assign v[1] = i_unmitigated_value;

    logic [33:0] trial [2];
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            trial[c] = {r_rem[c], r_dvd[c][QW-1]} - {2'b0, r_wt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dur   <= '0;
            r_rst_delay <= 32'(5) << FRAC_BITS;
            r_cnt <= '0; r_crit <= '0; r_wt <= '0; r_idle <= '0; r_run <= 1'b0;
            r_need <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_min[c] <= '0; r_max[c] <= '0; r_tsum[c] <= '0;
                r_tot[c] <= '0; r_rate[c] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == wrs_pkg::CFG_MAX_DUR) r_max_dur <= i_cfg_data;
                else r_rst_delay <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_need <= 1'b0;
                if (sample_ok) begin
                    r_run <= 1'b1;
                    r_cnt <= sadd32(r_cnt, 32'd1);
                    if (i_is_critical) r_crit <= sadd32(r_crit, 32'd1);
                    for (int c = 0; c < 2; c++) begin
                        logic signed [47:0] nt;
                        nt = sat48(49'(r_tot[c]) + 49'(v[c]));
                        if (r_min[c] == 0 || v[c] < r_min[c]) r_min[c] <= v[c];
                        if (v[c] > r_max[c]) r_max[c] <= v[c];
                        r_tsum[c] <= sat48(49'(r_tsum[c]) + 49'(v[c]));
                        r_tot[c] <= nt;
                        if ({1'b0, r_wt} > ONE) r_need <= 1'b1;
                        else r_rate[c] <= nt;
                    end
                end else if (i_req_type == wrs_pkg::REQ_TICK) begin
                    logic clr;
                    clr = (r_rst_delay != 0) && (r_tsum[1] == 0) && (idle_nx > r_rst_delay);
                    if (r_run) begin
                        if (!full) r_wt <= sadd32(r_wt, i_delta_time);
                        else begin
                            r_run <= 1'b0;
                            r_wt  <= r_max_dur;
                            if ({1'b0, r_max_dur} > ONE) r_need <= !clr;
                            else if (!clr) begin
                                r_rate[0] <= r_tot[0]; r_rate[1] <= r_tot[1];
                            end
                        end
                    end
                    if (r_rst_delay != 0) begin
                        if (r_tsum[1] == 0) r_idle <= idle_nx;
                        else r_idle <= '0;
                    end
                    r_tsum[0] <= '0; r_tsum[1] <= '0;
                    if (clr) begin
                        r_cnt <= '0; r_crit <= '0; r_wt <= '0; r_idle <= '0;
                        r_run <= 1'b0;
                        for (int c = 0; c < 2; c++) begin
                            r_min[c] <= '0; r_max[c] <= '0;
                            r_tot[c] <= '0; r_rate[c] <= '0;
                        end
                    end
                end else if (i_req_type == wrs_pkg::REQ_CLEAR) begin
                    r_cnt <= '0; r_crit <= '0; r_wt <= '0; r_idle <= '0;
                    r_run <= 1'b0;
                    for (int c = 0; c < 2; c++) begin
                        r_min[c] <= '0; r_max[c] <= '0; r_tsum[c] <= '0;
                        r_tot[c] <= '0; r_rate[c] <= '0;
                    end
                end
            end
            if (i_cmd.div_done) begin
                for (int c = 0; c < 2; c++) begin
                    logic [QW-1:0] qf;
                    logic signed [48:0] sq;
                    qf = {r_quo[c][QW-2:0], ~trial[c][33]};
                    if (qf > QW'(S48_MAX)) sq = 49'(S48_MAX);
                    else sq = 49'(qf[47:0]);
                    r_rate[c] <= sat48(r_neg[c] ? -sq : sq);
                end
            end
        end
    end

    // divider datapath, no reset needed
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 2; c++) begin
            if (i_cmd.div_start) begin
                logic [47:0] mag;
                mag = r_tot[c][47] ? 48'(-r_tot[c]) : 48'(r_tot[c]);
                r_neg[c] <= r_tot[c][47];
                r_rem[c] <= '0;
                r_quo[c] <= '0;
                r_dvd[c] <= QW'(mag) << FRAC_BITS;
            end else if (i_cmd.div_step) begin
                if (!trial[c][33]) r_rem[c] <= trial[c][32:0];
                else r_rem[c] <= {r_rem[c][31:0], r_dvd[c][QW-1]};
                r_dvd[c] <= r_dvd[c] << 1;
                r_quo[c] <= {r_quo[c][QW-2:0], ~trial[c][33]};
            end
        end
    end

    assign o_stat.need_div = r_need;
    assign o_sample_count = r_cnt;
    assign o_crit_count   = r_crit;
    assign o_in_progress  = r_run;
    assign o_window_time  = r_wt;
    assign o_mit_min   = r_min[0];
    assign o_mit_max   = r_max[0];
    assign o_mit_total = r_tot[0];
    assign o_mit_rate  = r_rate[0];
    assign o_unm_min   = r_min[1];
    assign o_unm_max   = r_max[1];
    assign o_unm_total = r_tot[1];
    assign o_unm_rate  = r_rate[1];
endmodule
`default_nettype wire

// ----- sv/windowed_rate_statistics_unit.sv -----
// Top level of the windowed rate statistics unit.
// Depends on wrs_pkg, wrs_ctrl and wrs_dpath.
//
//  channel | signals                         | role
//  --------+---------------------------------+---------------------------
//  in      | i_valid / o_ready, item fields  | sample, tick or clear item
//  out     | o_valid / i_ready, result fields| statistics after the item
//  cfg     | i_cfg_valid / o_cfg_ready       | max_duration, restart_delay
//
// One item at a time. Items needing no rate division pass through accept,
// check and present; a rate recompute adds a pass through the pair of
// bit-serial restoring dividers, 48+FRAC_BITS quotient bits at Q16.16.
// Synchronous active-low reset; restart_delay resets to 5 s.
// A stalled result holds until taken; the next item waits for it.
// Configuration writes are always accepted.
`default_nettype none
module windowed_rate_statistics_unit #(
    parameter int FRAC_BITS = wrs_pkg::FRAC_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [1:0]          i_req_type,
    input  wire  signed [31:0]  i_mitigated_value,
    input  wire  signed [31:0]  i_unmitigated_value,
    input  wire                 i_is_critical,
    input  wire  [31:0]         i_delta_time,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [31:0]         o_sample_count,
    output logic [31:0]         o_crit_count,
    output logic                o_in_progress,
    output logic [31:0]         o_window_time,
    output logic signed [31:0]  o_mit_min,
    output logic signed [31:0]  o_mit_max,
    output logic signed [47:0]  o_mit_total,
    output logic signed [47:0]  o_mit_rate,
    output logic signed [31:0]  o_unm_min,
    output logic signed [31:0]  o_unm_max,
    output logic signed [47:0]  o_unm_total,
    output logic signed [47:0]  o_unm_rate,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire  [31:0]         i_cfg_data
);
    // quotient bits: 48-bit magnitude scaled by the fraction
    localparam int DIV_STEPS = 48 + FRAC_BITS;

    wrs_pkg::t_cmd  cmd;
    wrs_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    wrs_ctrl #(.DIV_STEPS(DIV_STEPS)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_stat(stat), .o_cmd(cmd)
    );

    wrs_dpath #(.FRAC_BITS(FRAC_BITS), .DIV_STEPS(DIV_STEPS)) u_dpath (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_req_type, .i_mitigated_value, .i_unmitigated_value,
        .i_is_critical, .i_delta_time,
        .o_sample_count, .o_crit_count, .o_in_progress, .o_window_time,
        .o_mit_min, .o_mit_max, .o_mit_total, .o_mit_rate,
        .o_unm_min, .o_unm_max, .o_unm_total, .o_unm_rate
    );
endmodule
`default_nettype wire

// ----- sv/wrs_checker.sv -----
// Port-level checker for the windowed rate statistics unit, bound to the top.
// Depends on windowed_rate_statistics_unit_defines.svh.
`include "windowed_rate_statistics_unit_defines.svh"
`default_nettype none
module wrs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [31:0] o_sample_count,
    input wire [31:0] o_crit_count
);
    // one item in flight: never ready while a result is shown
    `WRS_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_valid, !o_ready, "ready while result pending")
    // an accepted item never yields a result in the very next cycle
    `WRS_ASSERT_NXT(a_lat, i_clk, i_rst_n, i_valid && o_ready, !o_valid, "result too early")
    // stalled result holds
    `WRS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_sample_count), "stalled result changed")
    // critical count never exceeds sample count
    `WRS_ASSERT_IMP(a_crit, i_clk, i_rst_n, o_valid, o_crit_count <= o_sample_count,
        "critical count above sample count")
endmodule
`default_nettype wire

bind windowed_rate_statistics_unit wrs_checker u_wrs_checker (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
    .o_sample_count, .o_crit_count
);
